>>> hdl/bne_pkg.sv
// ---------------------------------------------------------------------------
// bne_pkg
// Shared types, character codes and alphabet mapping for the base-N encoder.
// ---------------------------------------------------------------------------
package bne_pkg;

	typedef enum logic [1:0] {
		MODE_B64 = 2'd0,
		MODE_B32 = 2'd1,
		MODE_B16 = 2'd2
	} bne_mode_t;

	localparam logic [6:0] CH_UPPER_A = 7'h41;
	localparam logic [6:0] CH_LOWER_A = 7'h61;
	localparam logic [6:0] CH_DIGIT_0 = 7'h30;
	localparam logic [6:0] CH_DIGIT_2 = 7'h32;
	localparam logic [6:0] CH_PLUS    = 7'h2B;
	localparam logic [6:0] CH_SLASH   = 7'h2F;
	localparam logic [6:0] CH_PAD     = 7'h3D;

	localparam int unsigned MAX_CHARS = 3;

	typedef struct packed {
		logic [MAX_CHARS-1:0][6:0] chars;
		logic [1:0]                n_chars;
		logic [3:0]                n_total;
		logic                      fin;
	} bne_job_t;

	function automatic logic [6:0] map_char(input bne_mode_t mode, input logic [5:0] v);
		logic [6:0] w;
		logic [6:0] r;
		begin
			w = {1'b0, v};
			unique case (mode)
				MODE_B64: begin
					if (w < 7'd26)
						r = CH_UPPER_A + w;
					else if (w < 7'd52)
						r = CH_LOWER_A + (w - 7'd26);
					else if (w < 7'd62)
						r = CH_DIGIT_0 + (w - 7'd52);
					else if (w == 7'd62)
						r = CH_PLUS;
					else
						r = CH_SLASH;
				end
				MODE_B32: begin
					if (w[4:0] < 5'd26)
						r = CH_UPPER_A + {2'b0, w[4:0]};
					else
						r = CH_DIGIT_2 + ({2'b0, w[4:0]} - 7'd26);
				end
				default: begin
					if (w[3:0] < 4'd10)
						r = CH_DIGIT_0 + {3'b0, w[3:0]};
					else
						r = CH_UPPER_A + ({3'b0, w[3:0]} - 7'd10);
				end
			endcase
			return r;
		end
	endfunction

endpackage

>>> hdl/bne_slice.sv
// ---------------------------------------------------------------------------
// bne_slice
// Alphabet register, message bit buffer and the single-pass slicing of one
// word into characters, flush character and padding count.
// ---------------------------------------------------------------------------
module bne_slice import bne_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_mode,
	input  logic       take,
	input  logic [7:0] data_byte,
	input  logic       final_byte,
	output bne_job_t   job
);

	logic [1:0] mode_q;
	logic [3:0] pend_bits_q;
	logic [2:0] pend_cnt_q;
	logic [2:0] gp_q;

	bne_mode_t  mode;
	logic [2:0] gbits;
	logic [5:0] gmask;
	logic [2:0] gmod;
	logic [2:0] cnt_lo;
	logic [3:0] cnt;
	logic [11:0] acc;
	logic       two;
	logic [3:0] sh0;
	logic [3:0] sh1;
	logic [3:0] rem;
	logic [11:0] grp0_w;
	logic [11:0] grp1_w;
	logic [17:0] flush_w;
	logic [6:0] ch0;
	logic [6:0] ch1;
	logic [6:0] chf;
	logic       has_flush;
	logic [1:0] n_chars;
	logic [2:0] gp_after;
	logic [2:0] pad_raw;
	logic [3:0] room;
	logic [3:0] pads;
	logic [4:0] rem_mask_w;

	always_comb begin
		unique case (mode_q)
			MODE_B64: mode = MODE_B64;
			MODE_B32: mode = MODE_B32;
			default:  mode = MODE_B16;
		endcase
		unique case (mode)
			MODE_B64: begin
				gbits = 3'd6;
				gmask = 6'h3F;
				gmod  = 3'd3;
			end
			MODE_B32: begin
				gbits = 3'd5;
				gmask = 6'h1F;
				gmod  = 3'd7;
			end
			default: begin
				gbits = 3'd4;
				gmask = 6'h0F;
				gmod  = 3'd0;
			end
		endcase

		cnt_lo  = (pend_cnt_q > 3'd4) ? 3'd4 : pend_cnt_q;
		cnt     = {1'b0, cnt_lo} + 4'd8;
		acc     = {pend_bits_q, data_byte};
		two     = cnt >= {gbits, 1'b0};
		sh0     = cnt - {1'b0, gbits};
		sh1     = sh0 - {1'b0, gbits};
		rem     = two ? sh1 : sh0;

		grp0_w  = acc >> sh0;
		grp1_w  = acc >> sh1;
		flush_w = ({6'b0, acc} << gbits) >> rem;
		ch0     = map_char(mode, grp0_w[5:0] & gmask);
		ch1     = map_char(mode, grp1_w[5:0] & gmask);
		chf     = map_char(mode, flush_w[5:0] & gmask);

		has_flush = final_byte && (rem != 4'd0);
		n_chars   = (two ? 2'd2 : 2'd1) + {1'b0, has_flush};
		gp_after  = gp_q + {1'b0, n_chars};
		pad_raw   = final_byte ? ((3'd0 - gp_after) & gmod) : 3'd0;
		room      = 4'd8 - {2'b0, n_chars};
		pads      = ({1'b0, pad_raw} > room) ? room : {1'b0, pad_raw};
		rem_mask_w = (5'd1 << rem) - 5'd1;

		job.chars[0] = ch0;
		job.chars[1] = two ? ch1 : chf;
		job.chars[2] = chf;
		job.n_chars  = n_chars;
		job.n_total  = {2'b0, n_chars} + pads;
		job.fin      = final_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_B64;
			pend_bits_q <= '0;
			pend_cnt_q  <= '0;
			gp_q        <= '0;
		end else if (cfg_we) begin
			mode_q      <= cfg_mode;
			pend_bits_q <= '0;
			pend_cnt_q  <= '0;
			gp_q        <= '0;
		end else if (take) begin
			if (final_byte) begin
				pend_bits_q <= '0;
				pend_cnt_q  <= '0;
				gp_q        <= '0;
			end else begin
				pend_bits_q <= acc[3:0] & rem_mask_w[3:0];
				pend_cnt_q  <= rem[2:0];
				gp_q        <= gp_after;
			end
		end
	end

endmodule

>>> hdl/bne_emit.sv
// ---------------------------------------------------------------------------
// bne_emit
// Holds one sliced word and hands out its characters and padding one per
// cycle through the output register while char_stall does not hold it.
// ---------------------------------------------------------------------------
module bne_emit import bne_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  bne_job_t   job,
	input  logic       byte_valid,
	output logic       byte_stall,
	output logic       take,
	output logic       char_valid,
	input  logic       char_stall,
	output logic [6:0] text_char,
	output logic       item_done,
	output logic       message_done
);

	bne_job_t   job_s1;
	logic       job_valid_q;
	logic [2:0] idx_q;
	logic       out_valid_q;
	logic [6:0] char_q;
	logic       item_done_q;
	logic       msg_done_q;

	logic       out_free;
	logic       move;
	logic       last;
	logic [6:0] cur_char;

	always_comb begin
		out_free   = !out_valid_q || !char_stall;
		move       = job_valid_q && out_free;
		last       = ({1'b0, idx_q} == (job_s1.n_total - 4'd1));
		byte_stall = job_valid_q && !(move && last);
		take       = byte_valid && !byte_stall;
		if ({1'b0, idx_q} < {2'b0, job_s1.n_chars}) begin
			unique case (idx_q[1:0])
				2'd0:    cur_char = job_s1.chars[0];
				2'd1:    cur_char = job_s1.chars[1];
				default: cur_char = job_s1.chars[2];
			endcase
		end else begin
			cur_char = CH_PAD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take)
				job_valid_q <= 1'b1;
			else if (move && last)
				job_valid_q <= 1'b0;

			if (move)
				idx_q <= last ? 3'd0 : idx_q + 3'd1;

			if (move)
				out_valid_q <= 1'b1;
			else if (out_free)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			job_s1 <= job;
		if (move) begin
			char_q      <= cur_char;
			item_done_q <= last;
			msg_done_q  <= last && job_s1.fin;
		end
	end

	assign char_valid   = out_valid_q;
	assign text_char    = char_q;
	assign item_done    = item_done_q;
	assign message_done = msg_done_q;

`ifndef SYNTHESIS
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid_q |-> ({1'b0, idx_q} < job_s1.n_total))
		else $error("character index past end of word");

	a_total_range: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid_q |-> (job_s1.n_chars != 2'd0 && job_s1.n_total <= 4'd8
			&& job_s1.n_total >= {2'b0, job_s1.n_chars}))
		else $error("word holds an impossible character count");

	a_msg_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && msg_done_q |-> item_done_q)
		else $error("message end without word end");

	a_idle_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!job_valid_q |-> !byte_stall)
		else $error("stall raised with no word held");

	a_word_drains: assert property (@(posedge clk) disable iff (!arst_n)
		move && last && !take |=> !job_valid_q)
		else $error("finished word not released");
`endif

endmodule

>>> hdl/base_n_text_encoder.sv
// ---------------------------------------------------------------------------
// base_n_text_encoder
// Streaming base64 / base32 / base16 text encoder with '=' group padding.
// ---------------------------------------------------------------------------
//  channel  | direction | handshake             | payload
//  byte     | in        | byte_valid/byte_stall | data_byte, final_byte
//  char     | out       | char_valid/char_stall | text_char, item_done, message_done
//  cfg      | in        | cfg_valid/cfg_ready   | alphabet_mode
//
//  One character leaves per cycle while char_stall is low; a word yields 1 or
//  2 characters if ordinary, up to 8 if final with flush and padding. The
//  first character passes through the word register and then the output
//  register. A new word is taken in the cycle its predecessor's
//  last character moves to the output register. Reset selects base64 and
//  clears the bit buffer; cfg_ready is always high.
// ---------------------------------------------------------------------------
module base_n_text_encoder import bne_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_stall,
	input  logic [7:0] data_byte,
	input  logic       final_byte,
	output logic       char_valid,
	input  logic       char_stall,
	output logic [6:0] text_char,
	output logic       item_done,
	output logic       message_done,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] alphabet_mode
);

	bne_job_t job;
	logic     take;

	assign cfg_ready = 1'b1;

	bne_slice u_slice (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_mode   (alphabet_mode),
		.take       (take),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.job        (job)
	);

	bne_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.job          (job),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.take         (take),
		.char_valid   (char_valid),
		.char_stall   (char_stall),
		.text_char    (text_char),
		.item_done    (item_done),
		.message_done (message_done)
	);

endmodule
